>>> rtl/pair_energy_virial_tally_macros.svh
// Assertion macros shared by the pair energy and virial tally RTL.
// Included by the modules that carry concurrent assertions; needs clk and arst_n in scope.
`ifndef PAIR_ENERGY_VIRIAL_TALLY_MACROS_SVH
`define PAIR_ENERGY_VIRIAL_TALLY_MACROS_SVH

// Checked only while out of reset.
`define PEVT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PEVT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/pevt_pkg.sv
// Package for the pair energy and virial tally: types, codes, sizes and the saturating adder.
// No dependencies; imported by the controller, the datapath and the top module.
`default_nettype none
package pevt_pkg;

	localparam int NUM_ATOMS = 1024;
	localparam int ATOM_AW   = (NUM_ATOMS > 1) ? $clog2(NUM_ATOMS) : 1;
	localparam int NUM_VIR   = 6;
	localparam int ACC_W     = 64;
	localparam int IN_DATA_W = 216;

	localparam logic [2:0] REG_ENERGY_GLOBAL_EN = 3'd0;
	localparam logic [2:0] REG_ENERGY_ATOM_EN   = 3'd1;
	localparam logic [2:0] REG_VIRIAL_GLOBAL_EN = 3'd2;
	localparam logic [2:0] REG_VIRIAL_ATOM_EN   = 3'd3;
	localparam logic [2:0] REG_NEWTON_ON        = 3'd4;
	localparam logic [2:0] REG_LOCAL_COUNT      = 3'd5;

	localparam logic [2:0] COMP_VDW         = 3'd0;
	localparam logic [2:0] COMP_COUL        = 3'd1;
	localparam logic [2:0] COMP_GLOB_VIR0   = 3'd2;
	localparam logic [2:0] COMP_ATOM_ENERGY = 3'd0;
	localparam logic [2:0] COMP_ATOM_VIR0   = 3'd1;
	localparam logic [2:0] COMP_ATOM_NONE   = 3'd7;
	localparam logic [2:0] VIR_LAST         = 3'd5;

	typedef enum logic [1:0] {
		CMD_TALLY     = 2'd0,
		CMD_RD_GLOBAL = 2'd1,
		CMD_RD_ATOM   = 2'd2,
		CMD_CLEAR     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MS_NONE,
		MS_AB,
		MS_LO,
		MS_HI
	} mul_step_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_GLOBAL,
		RES_ATOM
	} res_sel_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_MUL_AB,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_VSUM,
		ST_ENERGY,
		ST_RD_I,
		ST_WR_I,
		ST_RD_J,
		ST_WR_J,
		ST_ATOM_RD,
		ST_CLEAR,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic              energy_global_en;
		logic              energy_atom_en;
		logic              virial_global_en;
		logic              virial_atom_en;
		logic              newton_on;
		logic [10:0]       local_count;
	} cfg_t;

	typedef struct packed {
		logic               load;
		mul_step_t          mstep;
		logic               vsum;
		logic [2:0]         k;
		logic               energy;
		logic               atom_rd;
		logic               atom_wr;
		logic               atom_sel_j;
		logic               clr_we;
		logic [ATOM_AW-1:0] clr_addr;
		logic               glob_clr;
		res_sel_t           res_sel;
		logic               out_load;
	} dp_cmd_t;

	typedef struct packed {
		cmd_t cmd;
	} dp_stat_t;

	// Sum of three signed values, clamped to the signed 64-bit range.
	function automatic logic signed [ACC_W-1:0] sat_add3(
		input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b,
		input logic signed [ACC_W-1:0] c
	);
		logic signed [ACC_W+1:0] s;
		logic [ACC_W-1:0] r;
		s = (ACC_W+2)'(a) + (ACC_W+2)'(b) + (ACC_W+2)'(c);
		if (s[ACC_W+1:ACC_W-1] == 3'b000 || s[ACC_W+1:ACC_W-1] == 3'b111) begin
			r = s[ACC_W-1:0];
		end else if (s[ACC_W+1]) begin
			r = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(ACC_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/pevt_ram.sv
// Generic single-port-write, registered-read RAM.
// Standalone; used by the datapath for the per-atom stores.
`default_nettype none
module pevt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH)-1:0]         waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic                             re,
	input  wire logic [$clog2(DEPTH)-1:0]         raddr,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/pevt_ctrl.sv
// Controller of the tally: sequences multiply steps, accumulation, store sweeps and results.
// Depends on pevt_pkg and the assertion macro header.
`default_nettype none
`include "pair_energy_virial_tally_macros.svh"
module pevt_ctrl
	import pevt_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire logic     out_free,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	state_t             state_q, state_d;
	logic [2:0]         k_q;
	logic [ATOM_AW-1:0] clr_q;
	logic               clr_last;
	logic               accept;

	assign clr_last = (clr_q == ATOM_AW'(NUM_ATOMS - 1));
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			k_q     <= '0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DECODE) begin
				k_q <= '0;
			end else if (state_q == ST_VSUM) begin
				k_q <= k_q + 3'd1;
			end
			if (state_q == ST_INIT || state_q == ST_CLEAR) begin
				clr_q <= clr_q + ATOM_AW'(1);
			end else begin
				clr_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT:    if (clr_last) state_d = ST_IDLE;
			ST_IDLE:    if (accept) state_d = ST_DECODE;
			ST_DECODE: begin
				unique case (stat.cmd)
					CMD_TALLY:     state_d = ST_MUL_AB;
					CMD_RD_GLOBAL: state_d = ST_RESULT;
					CMD_RD_ATOM:   state_d = ST_ATOM_RD;
					CMD_CLEAR:     state_d = ST_CLEAR;
					default:       state_d = ST_RESULT;
				endcase
			end
			ST_MUL_AB:  state_d = ST_MUL_LO;
			ST_MUL_LO:  state_d = ST_MUL_HI;
			ST_MUL_HI:  state_d = ST_VSUM;
			ST_VSUM:    state_d = (k_q == VIR_LAST) ? ST_ENERGY : ST_MUL_AB;
			ST_ENERGY:  state_d = ST_RD_I;
			ST_RD_I:    state_d = ST_WR_I;
			ST_WR_I:    state_d = ST_RD_J;
			ST_RD_J:    state_d = ST_WR_J;
			ST_WR_J:    state_d = ST_RESULT;
			ST_ATOM_RD: state_d = ST_RESULT;
			ST_CLEAR:   if (clr_last) state_d = ST_RESULT;
			ST_RESULT:  if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		cmd          = '0;
		cmd.mstep    = MS_NONE;
		cmd.res_sel  = RES_ZERO;
		cmd.k        = k_q;
		cmd.clr_addr = clr_q;
		cmd.load     = accept;
		unique case (state_q)
			ST_MUL_AB:  cmd.mstep = MS_AB;
			ST_MUL_LO:  cmd.mstep = MS_LO;
			ST_MUL_HI:  cmd.mstep = MS_HI;
			ST_VSUM:    cmd.vsum = 1'b1;
			ST_ENERGY:  cmd.energy = 1'b1;
			ST_RD_I:    cmd.atom_rd = 1'b1;
			ST_WR_I:    cmd.atom_wr = 1'b1;
			ST_RD_J: begin
				cmd.atom_rd    = 1'b1;
				cmd.atom_sel_j = 1'b1;
			end
			ST_WR_J: begin
				cmd.atom_wr    = 1'b1;
				cmd.atom_sel_j = 1'b1;
			end
			ST_ATOM_RD: cmd.atom_rd = 1'b1;
			ST_INIT:    cmd.clr_we = 1'b1;
			ST_CLEAR: begin
				cmd.clr_we   = 1'b1;
				cmd.glob_clr = 1'b1;
			end
			ST_RESULT: begin
				cmd.out_load = out_free;
				unique case (stat.cmd)
					CMD_RD_GLOBAL: cmd.res_sel = RES_GLOBAL;
					CMD_RD_ATOM:   cmd.res_sel = RES_ATOM;
					default:       cmd.res_sel = RES_ZERO;
				endcase
			end
			default: ;
		endcase
	end

	`PEVT_ASSERT(a_load_only_free, cmd.out_load |-> out_free, "result loaded over a pending one")
	`PEVT_ASSERT(a_clr_no_credit, cmd.clr_we |-> !cmd.atom_wr, "store sweep collided with a credit")
	`PEVT_ASSERT(a_accept_decode, accept |=> (state_q == ST_DECODE), "accepted request not decoded")
	`PEVT_ASSERT(a_vir_to_energy, (state_q == ST_VSUM && k_q == VIR_LAST) |=> (state_q == ST_ENERGY), "virial loop overran")

endmodule
`default_nettype wire

>>> rtl/pevt_dp.sv
// Datapath of the tally: request capture, shared multiplier, global accumulators, per-atom stores.
// Depends on pevt_pkg and pevt_ram.
`default_nettype none
module pevt_dp
	import pevt_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cfg_t                   cfg,
	input  wire dp_cmd_t                cmd,
	input  wire logic [1:0]             in_user,
	input  wire logic [IN_DATA_W-1:0]   in_data,
	output dp_stat_t                    stat,
	output logic signed [ACC_W-1:0]     read_value
);

	cmd_t               cmd_q;
	logic [9:0]         ai_q, aj_q;
	logic [2:0]         comp_q;
	logic signed [31:0] ev_q, ec_q, f_q, dx_q, dy_q, dz_q;

	logic signed [63:0] p_q;
	logic signed [64:0] lo_q;
	logic signed [63:0] hi_q;
	logic signed [ACC_W-1:0] vh_q [NUM_VIR];

	logic signed [ACC_W-1:0] sum_vdw_q, sum_coul_q;
	logic signed [ACC_W-1:0] sum_vir_q [NUM_VIR];

	logic signed [31:0] op_a, op_b;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic signed [63:0] v_full, v_half;
	logic signed [63:0] ev_full, ec_full, ev_half, ec_half, e_pair_half;
	logic signed [32:0] e_pair;
	logic               own_i, own_j;

	logic [9:0]                 atom_idx;
	logic                       atom_in_range, ai_in_range, credit;
	logic [ATOM_AW-1:0]         ram_addr;
	logic                       we_e, we_v;
	logic [ACC_W-1:0]           wdata_e, rdata_e;
	logic [NUM_VIR*ACC_W-1:0]   wdata_v, rdata_v;
	logic signed [ACC_W-1:0]    vlane [NUM_VIR];

	assign stat.cmd = cmd_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= cmd_t'(in_user);
			ai_q   <= in_data[9:0];
			aj_q   <= in_data[19:10];
			comp_q <= in_data[22:20];
			ev_q   <= in_data[54:23];
			ec_q   <= in_data[86:55];
			f_q    <= in_data[118:87];
			dx_q   <= in_data[150:119];
			dy_q   <= in_data[182:151];
			dz_q   <= in_data[214:183];
		end
	end

	// Component order: xx, yy, zz, xy, xz, yz.
	always_comb begin
		unique case (cmd.k)
			3'd0: begin op_a = dx_q; op_b = dx_q; end
			3'd1: begin op_a = dy_q; op_b = dy_q; end
			3'd2: begin op_a = dz_q; op_b = dz_q; end
			3'd3: begin op_a = dx_q; op_b = dy_q; end
			3'd4: begin op_a = dx_q; op_b = dz_q; end
			default: begin op_a = dy_q; op_b = dz_q; end
		endcase
	end

	// The 64-bit pair product times the force is split into a low unsigned half and a
	// signed high half; floor(p*f / 2^32) = hi*f + floor(lo*f / 2^32).
	always_comb begin
		unique case (cmd.mstep)
			MS_AB: begin
				mul_a = {op_a[31], op_a};
				mul_b = {op_b[31], op_b};
			end
			MS_LO: begin
				mul_a = {1'b0, p_q[31:0]};
				mul_b = {f_q[31], f_q};
			end
			MS_HI: begin
				mul_a = {p_q[63], p_q[63:32]};
				mul_b = {f_q[31], f_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		unique case (cmd.mstep)
			MS_AB:   p_q  <= mul_p[63:0];
			MS_LO:   lo_q <= mul_p[64:0];
			MS_HI:   hi_q <= mul_p[63:0];
			default: ;
		endcase
		if (cmd.vsum) begin
			vh_q[cmd.k] <= v_half;
		end
	end

	assign v_full = hi_q + {{31{lo_q[64]}}, lo_q[64:32]};
	assign v_half = {v_full[63], v_full[63:1]};

	assign own_i = ({1'b0, ai_q} < cfg.local_count);
	assign own_j = ({1'b0, aj_q} < cfg.local_count);

	assign ev_full     = 64'(ev_q);
	assign ec_full     = 64'(ec_q);
	assign ev_half     = ev_full >>> 1;
	assign ec_half     = ec_full >>> 1;
	assign e_pair      = 33'(ev_q) + 33'(ec_q);
	assign e_pair_half = 64'(e_pair >>> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_vdw_q  <= '0;
			sum_coul_q <= '0;
			for (int n = 0; n < NUM_VIR; n++) begin
				sum_vir_q[n] <= '0;
			end
		end else if (cmd.glob_clr) begin
			sum_vdw_q  <= '0;
			sum_coul_q <= '0;
			for (int n = 0; n < NUM_VIR; n++) begin
				sum_vir_q[n] <= '0;
			end
		end else begin
			if (cmd.energy && cfg.energy_global_en) begin
				if (cfg.newton_on) begin
					sum_vdw_q  <= sat_add3(sum_vdw_q, ev_full, '0);
					sum_coul_q <= sat_add3(sum_coul_q, ec_full, '0);
				end else begin
					sum_vdw_q  <= sat_add3(sum_vdw_q, own_i ? ev_half : '0,
						own_j ? ev_half : '0);
					sum_coul_q <= sat_add3(sum_coul_q, own_i ? ec_half : '0,
						own_j ? ec_half : '0);
				end
			end
			if (cmd.vsum && cfg.virial_global_en) begin
				if (cfg.newton_on) begin
					sum_vir_q[cmd.k] <= sat_add3(sum_vir_q[cmd.k], v_full, '0);
				end else begin
					sum_vir_q[cmd.k] <= sat_add3(sum_vir_q[cmd.k], own_i ? v_half : '0,
						own_j ? v_half : '0);
				end
			end
		end
	end

	// Per-atom stores: one energy row and one six-lane virial row per atom.
	assign atom_idx      = cmd.atom_sel_j ? aj_q : ai_q;
	assign atom_in_range = ({22'b0, atom_idx} < 32'(NUM_ATOMS));
	assign ai_in_range   = ({22'b0, ai_q} < 32'(NUM_ATOMS));
	assign credit        = cmd.atom_wr && atom_in_range &&
		(cfg.newton_on || (cmd.atom_sel_j ? own_j : own_i));
	assign ram_addr      = cmd.clr_we ? cmd.clr_addr : ATOM_AW'(atom_idx);
	assign we_e          = cmd.clr_we || (credit && cfg.energy_atom_en);
	assign we_v          = cmd.clr_we || (credit && cfg.virial_atom_en);
	assign wdata_e       = cmd.clr_we ? '0 : sat_add3(rdata_e, e_pair_half, '0);

	for (genvar g = 0; g < NUM_VIR; g++) begin : g_lane
		assign vlane[g] = rdata_v[g*ACC_W +: ACC_W];
		assign wdata_v[g*ACC_W +: ACC_W] = cmd.clr_we ? '0 : sat_add3(vlane[g], vh_q[g], '0);
	end

	pevt_ram #(
		.WIDTH (ACC_W),
		.DEPTH (NUM_ATOMS)
	) u_energy_ram (
		.clk   (clk),
		.we    (we_e),
		.waddr (ram_addr),
		.wdata (wdata_e),
		.re    (cmd.atom_rd),
		.raddr (ram_addr),
		.rdata (rdata_e)
	);

	pevt_ram #(
		.WIDTH (NUM_VIR * ACC_W),
		.DEPTH (NUM_ATOMS)
	) u_virial_ram (
		.clk   (clk),
		.we    (we_v),
		.waddr (ram_addr),
		.wdata (wdata_v),
		.re    (cmd.atom_rd),
		.raddr (ram_addr),
		.rdata (rdata_v)
	);

	always_comb begin
		read_value = '0;
		unique case (cmd.res_sel)
			RES_GLOBAL: begin
				if (comp_q == COMP_VDW) begin
					read_value = sum_vdw_q;
				end else if (comp_q == COMP_COUL) begin
					read_value = sum_coul_q;
				end else begin
					read_value = sum_vir_q[comp_q - COMP_GLOB_VIR0];
				end
			end
			RES_ATOM: begin
				if (!ai_in_range || comp_q == COMP_ATOM_NONE) begin
					read_value = '0;
				end else if (comp_q == COMP_ATOM_ENERGY) begin
					read_value = rdata_e;
				end else begin
					read_value = vlane[comp_q - COMP_ATOM_VIR0];
				end
			end
			default: read_value = '0;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/pair_energy_virial_tally.sv
// Pair energy and virial tally unit: configuration registers, output register and the
// controller/datapath pair. Depends on pevt_pkg, pevt_ctrl and pevt_dp.
//
// Use: requests arrive on the s_ channel; s_tuser carries the command (tally a pair,
// read a global sum, read a per-atom entry, clear everything) and s_tdata the operands.
// Every request, whatever its kind, returns exactly one 64-bit Q48.16 word on the m_
// channel: the value read, or zero for a tally or a clear.
// One request is worked on at a time. A tally runs through a decode step, then six
// virial components (three steps through the one shared 33 by 33 bit multiplier and a
// sum step each), then the global energy update, a read and a write of the per-atom
// store rows for each of the two atoms, and the result step. A global read goes from
// decode to the result step, a per-atom read passes one store read first, and a clear
// sweeps the per-atom stores, one store row per cycle.
// The result sits in an output register, so the next request is taken while it waits;
// if the receiver stalls and a second result is ready, the unit holds it and accepts
// nothing further until the register frees.
// After reset the per-atom stores are swept to zero while s_tready stays low;
// configuration writes are taken at any time but are meant for an idle unit.
`default_nettype none
module pair_energy_virial_tally
	import pevt_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// atom_i, atom_j, component, energy_vdw, energy_coul, force_scalar, delta_x,
	// delta_y, delta_z (lowest bit up), one zero pad bit on top
	input  wire logic [IN_DATA_W-1:0] s_tdata,
	// cmd
	input  wire logic [1:0]           s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// read_value
	output logic [ACC_W-1:0]          m_tdata,
	input  wire logic                 cfg_we,
	input  wire logic [2:0]           cfg_addr,
	input  wire logic [10:0]          cfg_wdata
);

	cfg_t                    cfg_q;
	dp_cmd_t                 dcmd;
	dp_stat_t                dstat;
	logic signed [ACC_W-1:0] read_value;
	logic                    out_free;
	logic                    m_tvalid_q;
	logic [ACC_W-1:0]        m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.energy_global_en <= 1'b1;
			cfg_q.energy_atom_en   <= 1'b0;
			cfg_q.virial_global_en <= 1'b1;
			cfg_q.virial_atom_en   <= 1'b0;
			cfg_q.newton_on        <= 1'b1;
			cfg_q.local_count      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ENERGY_GLOBAL_EN: cfg_q.energy_global_en <= cfg_wdata[0];
				REG_ENERGY_ATOM_EN:   cfg_q.energy_atom_en   <= cfg_wdata[0];
				REG_VIRIAL_GLOBAL_EN: cfg_q.virial_global_en <= cfg_wdata[0];
				REG_VIRIAL_ATOM_EN:   cfg_q.virial_atom_en   <= cfg_wdata[0];
				REG_NEWTON_ON:        cfg_q.newton_on        <= cfg_wdata[0];
				REG_LOCAL_COUNT:      cfg_q.local_count      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (dcmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.out_load) begin
			m_tdata_q <= read_value;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	pevt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_free (out_free),
		.stat     (dstat),
		.cmd      (dcmd)
	);

	pevt_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd        (dcmd),
		.in_user    (s_tuser),
		.in_data    (s_tdata),
		.stat       (dstat),
		.read_value (read_value)
	);

endmodule
`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for the pair energy and virial tally unit.
// Depends on pevt_pkg and the pair_energy_virial_tally RTL; drives requests, predicts the
// read words and compares every result against the prediction.
`default_nettype none
module tb_top;
	import pevt_pkg::*;

	localparam int LIMIT = 4000000;

	typedef struct {
		cmd_t        cmd;
		logic [9:0]  ai;
		logic [9:0]  aj;
		logic [2:0]  comp;
		logic [31:0] ev;
		logic [31:0] ec;
		logic [31:0] fs;
		logic [31:0] dx;
		logic [31:0] dy;
		logic [31:0] dz;
		logic        has_gold;
		logic [63:0] gold;
	} req_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [1:0]        s_tuser = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [ACC_W-1:0]  m_tdata;
	logic              cfg_we = 1'b0;
	logic [2:0]        cfg_addr = '0;
	logic [10:0]       cfg_wdata = '0;

	// Predictor state and configuration.
	logic        en_eg, en_ea, en_vg, en_va, newton;
	logic [10:0] lcount;
	logic signed [63:0] acc_vdw, acc_coul;
	logic signed [63:0] acc_vir [6];
	logic signed [63:0] atom_en [NUM_ATOMS];
	logic signed [63:0] atom_vir [NUM_ATOMS][6];

	logic [63:0] read_queue[$];
	int          n_errors = 0;
	int          n_results = 0;
	int          n_reqs = 0;
	longint      cycles = 0;
	bit          done = 1'b0;

	pair_energy_virial_tally u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic logic signed [63:0] sat_sum(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		return s[63:0];
	endfunction

	// Exact triple product floored to Q.16; arithmetic shift floors.
	function automatic logic signed [63:0] vir_product(logic [31:0] a, logic [31:0] b,
		logic [31:0] f);
		logic signed [127:0] p;
		p = 128'(signed'(a)) * 128'(signed'(b)) * 128'(signed'(f));
		return 64'(p >>> 32);
	endfunction

	function automatic logic signed [63:0] halve(logic signed [63:0] x);
		return x >>> 1;
	endfunction

	function automatic void clear_accs();
		acc_vdw = 0;
		acc_coul = 0;
		for (int k = 0; k < 6; k++) acc_vir[k] = 0;
		for (int a = 0; a < NUM_ATOMS; a++) begin
			atom_en[a] = 0;
			for (int k = 0; k < 6; k++) atom_vir[a][k] = 0;
		end
	endfunction

	function automatic void credit_atom(logic [9:0] idx, logic ok, logic signed [63:0] eh,
		logic signed [63:0] vh [6]);
		if (!ok) return;
		if (en_ea) atom_en[idx] = sat_sum(atom_en[idx], eh);
		if (en_va)
			for (int k = 0; k < 6; k++) atom_vir[idx][k] = sat_sum(atom_vir[idx][k], vh[k]);
	endfunction

	function automatic logic [63:0] predict_read_word(req_t r);
		logic signed [63:0] v [6];
		logic signed [63:0] vh [6];
		logic signed [63:0] ev, ec, eh;
		logic own_i, own_j;
		logic [63:0] word;
		word = '0;
		case (r.cmd)
			CMD_TALLY: begin
				ev = 64'(signed'(r.ev));
				ec = 64'(signed'(r.ec));
				own_i = {1'b0, r.ai} < lcount;
				own_j = {1'b0, r.aj} < lcount;
				if (en_eg) begin
					if (newton) begin
						acc_vdw = sat_sum(acc_vdw, ev);
						acc_coul = sat_sum(acc_coul, ec);
					end else begin
						if (own_i) begin
							acc_vdw = sat_sum(acc_vdw, halve(ev));
							acc_coul = sat_sum(acc_coul, halve(ec));
						end
						if (own_j) begin
							acc_vdw = sat_sum(acc_vdw, halve(ev));
							acc_coul = sat_sum(acc_coul, halve(ec));
						end
					end
				end
				v[0] = vir_product(r.dx, r.dx, r.fs);
				v[1] = vir_product(r.dy, r.dy, r.fs);
				v[2] = vir_product(r.dz, r.dz, r.fs);
				v[3] = vir_product(r.dx, r.dy, r.fs);
				v[4] = vir_product(r.dx, r.dz, r.fs);
				v[5] = vir_product(r.dy, r.dz, r.fs);
				for (int k = 0; k < 6; k++) vh[k] = halve(v[k]);
				if (en_vg)
					for (int k = 0; k < 6; k++) begin
						if (newton) acc_vir[k] = sat_sum(acc_vir[k], v[k]);
						else begin
							if (own_i) acc_vir[k] = sat_sum(acc_vir[k], vh[k]);
							if (own_j) acc_vir[k] = sat_sum(acc_vir[k], vh[k]);
						end
					end
				eh = halve(ev + ec);
				credit_atom(r.ai, newton || own_i, eh, vh);
				credit_atom(r.aj, newton || own_j, eh, vh);
			end
			CMD_RD_GLOBAL: begin
				if (r.comp == COMP_VDW) word = acc_vdw;
				else if (r.comp == COMP_COUL) word = acc_coul;
				else word = acc_vir[r.comp - COMP_GLOB_VIR0];
			end
			CMD_RD_ATOM: begin
				if (r.comp == COMP_ATOM_ENERGY) word = atom_en[r.ai];
				else if (r.comp != COMP_ATOM_NONE) word = atom_vir[r.ai][r.comp - COMP_ATOM_VIR0];
			end
			default: clear_accs();
		endcase
		return word;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [10:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ENERGY_GLOBAL_EN: en_eg = val[0];
			REG_ENERGY_ATOM_EN:   en_ea = val[0];
			REG_VIRIAL_GLOBAL_EN: en_vg = val[0];
			REG_VIRIAL_ATOM_EN:   en_va = val[0];
			REG_NEWTON_ON:        newton = val[0];
			default:              lcount = val;
		endcase
	endtask

	// The request stays valid past its accepting edge; the next one either replaces it at
	// the following falling edge or the line drops for the drawn number of idle cycles.
	task automatic send_request(req_t r);
		logic [63:0] word;
		int idle;
		idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
		@(negedge clk);
		if (idle != 0) begin
			s_tvalid <= 1'b0;
			repeat (idle) @(negedge clk);
		end
		s_tdata <= {1'b0, r.dz, r.dy, r.dx, r.fs, r.ec, r.ev, r.comp, r.aj, r.ai};
		s_tuser <= r.cmd;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		word = predict_read_word(r);
		if (r.has_gold && word !== r.gold)
			report_mismatch("directed expectation", r.gold, word);
		read_queue.push_back(word);
		n_reqs++;
	endtask

	task automatic release_bus();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
		$display("mismatch on %s: expected %h, got %h", what, want, got);
		n_errors++;
	endtask

	task automatic drain();
		release_bus();
		while (read_queue.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	function automatic req_t rand_req(cmd_t c, int hot);
		req_t r;
		r.cmd = c;
		r.ai = (hot != 0) ? 10'($urandom_range(0, 7)) : 10'($urandom);
		r.aj = (hot != 0) ? 10'($urandom_range(0, 7)) : 10'($urandom);
		r.comp = 3'($urandom);
		r.ev = $urandom; r.ec = $urandom; r.fs = $urandom;
		r.dx = $urandom; r.dy = $urandom; r.dz = $urandom;
		if ($urandom_range(0, 1)) begin
			// Moderate magnitudes so sums stay away from the rails most of the time.
			r.fs = 32'(signed'(r.fs) >>> 12);
			r.dx = 32'(signed'(r.dx) >>> 10);
			r.dy = 32'(signed'(r.dy) >>> 10);
			r.dz = 32'(signed'(r.dz) >>> 10);
		end
		r.has_gold = 1'b0;
		r.gold = '0;
		return r;
	endfunction

	// Result side: random stalls, one result checked per handshake.
	initial begin
		int stall;
		logic [63:0] want;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
			@(negedge clk);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			n_results++;
			if (read_queue.size() == 0) begin
				$display("result %h arrived with nothing expected", m_tdata);
				n_errors++;
			end else begin
				want = read_queue.pop_front();
				if (m_tdata !== want) report_mismatch("read_value", want, m_tdata);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT && !done) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		req_t dir [$];
		req_t r;
		int sel;
		logic [31:0] mx, mn;
		mx = 32'h7fffffff;
		mn = 32'h80000000;
		en_eg = 1; en_ea = 0; en_vg = 1; en_va = 0; newton = 1; lcount = 0;
		clear_accs();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table: fresh reads are zero, extreme tallies, every command.
		r = rand_req(CMD_RD_GLOBAL, 0); r.comp = COMP_VDW; r.has_gold = 1; dir.push_back(r);
		r = rand_req(CMD_RD_ATOM, 0); r.comp = COMP_ATOM_ENERGY; r.ai = 10'd1023;
		r.has_gold = 1; dir.push_back(r);
		r = rand_req(CMD_TALLY, 0); r.ev = mx; r.ec = mn; r.fs = mx; r.dx = mn; r.dy = mn;
		r.dz = mx; r.has_gold = 1; dir.push_back(r);
		r = rand_req(CMD_TALLY, 0); r.ev = mn; r.ec = mx; r.fs = mn; r.dx = mn; r.dy = mx;
		r.dz = mn; r.ai = 10'd1023; r.aj = 10'd1023; dir.push_back(r);
		for (int c = 0; c < 8; c++) begin
			r = rand_req(CMD_RD_GLOBAL, 0); r.comp = 3'(c); dir.push_back(r);
		end
		r = rand_req(CMD_CLEAR, 0); r.has_gold = 1; dir.push_back(r);
		r = rand_req(CMD_RD_GLOBAL, 0); r.comp = 3'd7; r.has_gold = 1; dir.push_back(r);
		foreach (dir[n]) send_request(dir[n]);
		drain();

		// Several settings, extremes included; each phase a mix of tallies, reads and occasional clears.
		for (int ph = 0; ph < 10; ph++) begin
			write_reg(REG_ENERGY_GLOBAL_EN, (ph == 3) ? 11'h7fe : 11'($urandom));
			write_reg(REG_ENERGY_ATOM_EN, (ph < 2) ? 11'd1 : 11'($urandom));
			write_reg(REG_VIRIAL_GLOBAL_EN, 11'($urandom));
			write_reg(REG_VIRIAL_ATOM_EN, (ph < 2) ? 11'h7ff : 11'($urandom));
			write_reg(REG_NEWTON_ON, 11'(ph & 1));
			case (ph % 4)
				0: write_reg(REG_LOCAL_COUNT, 11'd0);
				1: write_reg(REG_LOCAL_COUNT, 11'h7ff);
				2: write_reg(REG_LOCAL_COUNT, 11'd4);
				default: write_reg(REG_LOCAL_COUNT, 11'($urandom));
			endcase
			for (int n = 0; n < 200; n++) begin
				sel = $urandom_range(0, 99);
				if (sel < 55) r = rand_req(CMD_TALLY, $urandom_range(0, 1));
				else if (sel < 75) r = rand_req(CMD_RD_GLOBAL, 0);
				else if (sel < 99) r = rand_req(CMD_RD_ATOM, $urandom_range(0, 2));
				else r = rand_req(CMD_CLEAR, 0);
				send_request(r);
				if (n == 100) begin
					release_bus();
					while (read_queue.size() != 0) @(negedge clk);
				end
			end
			drain();
		end

		done = 1'b1;
		$display("covered %0d requests and %0d results over ten register settings,", n_reqs,
			n_results);
		$display("including both ownership modes, saturating extremes and clears");
		if (n_errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/pevt_pkg.sv
rtl/pevt_ram.sv
rtl/pevt_ctrl.sv
rtl/pevt_dp.sv
rtl/pair_energy_virial_tally.sv
dv/tb_top.sv
